// ===== sv/abld_pkg.sv =====
// ----------------------------------------------------------------------------
// abld_pkg
// Shared types, register codes and arithmetic helpers of the anchor box decoder.
// ----------------------------------------------------------------------------
package abld_pkg;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int NUM_ANCHOR_REGS = 4;

    localparam logic signed [15:0] LOG2E_Q14 = 16'sd23637;

    typedef enum logic [2:0] {
        REG_STRIDE    = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_IN_USE    = 3'd2,
        REG_ANCHOR_0  = 3'd3,
        REG_ANCHOR_1  = 3'd4,
        REG_ANCHOR_2  = 3'd5,
        REG_ANCHOR_3  = 3'd6
    } t_reg_idx;

    typedef logic [NUM_ANCHOR_REGS-1:0][63:0] t_anchor_set;

    typedef struct packed {
        logic               kind;
        logic [7:0]         row;
        logic [7:0]         col;
        logic [1:0]         ai;
        logic [15:0]        score;
        logic signed [15:0] da;
        logic signed [15:0] db;
        logic signed [15:0] dc;
        logic signed [15:0] dd;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         row;
        logic [7:0]         col;
        logic [1:0]         ai;
        logic [15:0]        score;
    } t_meta;

    typedef struct packed {
        t_meta              meta;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic               clip;
    } t_result;

    typedef struct packed {
        logic signed [15:0] q;
        logic               clip;
    } t_q4;

    // 2^(k/16) in Q.16
    function automatic logic [17:0] pow2_frac(input logic [4:0] k);
        logic [17:0] t;
        case (k)
            5'd0:    t = 18'd65536;
            5'd1:    t = 18'd68438;
            5'd2:    t = 18'd71468;
            5'd3:    t = 18'd74632;
            5'd4:    t = 18'd77936;
            5'd5:    t = 18'd81386;
            5'd6:    t = 18'd84990;
            5'd7:    t = 18'd88752;
            5'd8:    t = 18'd92682;
            5'd9:    t = 18'd96785;
            5'd10:   t = 18'd101070;
            5'd11:   t = 18'd105545;
            5'd12:   t = 18'd110218;
            5'd13:   t = 18'd115098;
            5'd14:   t = 18'd120194;
            5'd15:   t = 18'd125515;
            5'd16:   t = 18'd131072;
            default: t = 18'd131072;
        endcase
        return t;
    endfunction

    // Q.21 to Q12.4, round half up, saturate
    function automatic t_q4 to_q4(input logic signed [50:0] v);
        logic signed [50:0] r;
        t_q4 res;
        r = (v + 51'sd65536) >>> 17;
        res.clip = 1'b0;
        if (r > 51'sd32767) begin
            res.q = 16'sd32767;
            res.clip = 1'b1;
        end else if (r < -51'sd32768) begin
            res.q = -16'sd32768;
            res.clip = 1'b1;
        end else begin
            res.q = r[15:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/abld_fifo.sv =====
// ----------------------------------------------------------------------------
// abld_fifo
// Small register queue with the head visible on the read side.
// ----------------------------------------------------------------------------
module abld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
endmodule

// ===== sv/abld_front.sv =====
// ----------------------------------------------------------------------------
// abld_front
// Takes input items, drops those that yield no result, registers the rest.
// ----------------------------------------------------------------------------
module abld_front #(
    parameter int MAX_ANCHORS = 4,
    parameter int GRID_SIZE   = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  abld_pkg::t_item i_item,
    input  logic [15:0]    i_threshold,
    input  logic [2:0]     i_in_use,
    output logic           o_valid,
    output abld_pkg::t_item o_item
);
    import abld_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    logic  keep;

    always_comb begin
        keep = (i_item.score >= i_threshold)
            && ({1'b0, i_item.ai} < i_in_use)
            && (32'(i_item.ai) < MAX_ANCHORS)
            && (32'(i_item.row) < GRID_SIZE)
            && (32'(i_item.col) < GRID_SIZE);
        n_valid = i_accept && keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== sv/abld_back.sv =====
// ----------------------------------------------------------------------------
// abld_back
// Four-stage decode pipeline: anchor placement, exp, scaling, corner rounding.
// ----------------------------------------------------------------------------
module abld_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  abld_pkg::t_item     i_item,
    input  logic [6:0]          i_stride,
    input  abld_pkg::t_anchor_set i_anchor,
    output logic                o_valid,
    output abld_pkg::t_result   o_result
);
    import abld_pkg::*;

    // stage 1: anchor select, cell offset, exponent product
    logic               r1_v;
    t_meta              r1_meta;
    logic signed [15:0] r1_dx, r1_dy, r1_ax1, r1_ay1, r1_ax2, r1_ay2;
    logic [14:0]        r1_offx, r1_offy;
    logic signed [31:0] r1_pw, r1_ph;
    logic [63:0]        anc;

    // stage 2: size, centre sum, mantissa
    logic               r2_v;
    t_meta              r2_meta;
    logic signed [15:0] r2_dx, r2_dy;
    logic signed [17:0] r2_w, r2_h;
    logic signed [22:0] r2_sx, r2_sy;
    logic [17:0]        r2_mw, r2_mh;
    logic signed [5:0]  r2_nw, r2_nh;
    logic [17:0]        mw, mh;

    // stage 3: products
    logic               r3_v;
    t_meta              r3_meta;
    logic signed [33:0] r3_cxp, r3_cyp;
    logic signed [36:0] r3_vw, r3_vh;
    logic signed [5:0]  r3_nw, r3_nh;
    logic signed [22:0] r3_sx, r3_sy;

    // stage 4: centre and half size in Q.21
    logic               r4_v;
    t_meta              r4_meta;
    logic signed [41:0] r4_cx, r4_cy;
    logic signed [48:0] r4_hw, r4_hh;

    function automatic logic [17:0] mant(input logic [15:0] f);
        logic [17:0] t0, t1;
        logic [12:0] diff;
        logic [24:0] prod;
        t0   = pow2_frac({1'b0, f[15:12]});
        t1   = pow2_frac(5'({1'b0, f[15:12]} + 5'd1));
        diff = 13'(t1 - t0);
        prod = 25'(diff) * 25'(f[11:0]);
        return t0 + 18'(prod[24:12]);
    endfunction

    function automatic logic signed [48:0] half_size(input logic signed [36:0] v,
                                                      input logic signed [5:0] n);
        logic signed [47:0] ve, sz;
        logic [5:0]         amt;
        ve  = 48'(v);
        amt = n[5] ? 6'(-n) : 6'(n);
        sz  = n[5] ? (ve >>> amt) : (ve <<< amt);
        return 49'(sz) - 49'sd1048576;
    endfunction

    assign anc = i_anchor[i_item.ai];

    always_ff @(posedge i_clk) begin
        r1_meta <= '{i_item.kind, i_item.row, i_item.col, i_item.ai, i_item.score};
        r1_dx   <= i_item.da;
        r1_dy   <= i_item.db;
        r1_ax1  <= anc[15:0];
        r1_ay1  <= anc[31:16];
        r1_ax2  <= anc[47:32];
        r1_ay2  <= anc[63:48];
        r1_offx <= 15'(i_item.col) * 15'(i_stride);
        r1_offy <= 15'(i_item.row) * 15'(i_stride);
        r1_pw   <= 32'(i_item.dc) * 32'(LOG2E_Q14);
        r1_ph   <= 32'(i_item.dd) * 32'(LOG2E_Q14);
    end

    assign mw = mant(r1_pw[25:10]);
    assign mh = mant(r1_ph[25:10]);

    always_ff @(posedge i_clk) begin
        r2_meta <= r1_meta;
        r2_dx   <= r1_dx;
        r2_dy   <= r1_dy;
        r2_w    <= 18'(r1_ax2) - 18'(r1_ax1) + 18'sd16;
        r2_h    <= 18'(r1_ay2) - 18'(r1_ay1) + 18'sd16;
        r2_sx   <= $signed({3'b000, r1_offx, 5'b00000}) + 23'(r1_ax1) + 23'(r1_ax2);
        r2_sy   <= $signed({3'b000, r1_offy, 5'b00000}) + 23'(r1_ay1) + 23'(r1_ay2);
        r2_mw   <= mw;
        r2_mh   <= mh;
        r2_nw   <= r1_pw[31:26];
        r2_nh   <= r1_ph[31:26];
    end

    always_ff @(posedge i_clk) begin
        r3_meta <= r2_meta;
        r3_cxp  <= 34'(r2_dx) * 34'(r2_w);
        r3_cyp  <= 34'(r2_dy) * 34'(r2_h);
        r3_vw   <= 37'($signed({1'b0, r2_mw})) * 37'(r2_w);
        r3_vh   <= 37'($signed({1'b0, r2_mh})) * 37'(r2_h);
        r3_nw   <= r2_nw;
        r3_nh   <= r2_nh;
        r3_sx   <= r2_sx;
        r3_sy   <= r2_sy;
    end

    always_ff @(posedge i_clk) begin
        r4_meta <= r3_meta;
        r4_cx   <= (42'(r3_cxp) <<< 5) + (42'(r3_sx) <<< 16);
        r4_cy   <= (42'(r3_cyp) <<< 5) + (42'(r3_sy) <<< 16);
        r4_hw   <= half_size(r3_vw, r3_nw);
        r4_hh   <= half_size(r3_vh, r3_nh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_comb begin
        t_q4 qx1, qy1, qx2, qy2;
        if (r4_meta.kind == 1'b0) begin
            qx1 = to_q4(51'(r4_cx) - 51'(r4_hw));
            qy1 = to_q4(51'(r4_cy) - 51'(r4_hh));
            qx2 = to_q4(51'(r4_cx) + 51'(r4_hw));
            qy2 = to_q4(51'(r4_cy) + 51'(r4_hh));
        end else begin
            qx1 = to_q4(51'(r4_cx));
            qy1 = to_q4(51'(r4_cy));
            qx2 = '0;
            qy2 = '0;
        end
        o_result.meta = r4_meta;
        o_result.x1   = qx1.q;
        o_result.y1   = qy1.q;
        o_result.x2   = qx2.q;
        o_result.y2   = qy2.q;
        o_result.clip = qx1.clip | qy1.clip | qx2.clip | qy2.clip;
    end

    assign o_valid = r4_v;
endmodule

// ===== sv/anchor_box_landmark_decoder.sv =====
// ----------------------------------------------------------------------------
// anchor_box_landmark_decoder
// Decodes detector head items into face boxes or landmark points.
// ----------------------------------------------------------------------------
// One item is accepted per clock while full is low. A filter stage drops items
// with a score below the threshold, an anchor not in use or a cell off the grid;
// kept items wait in a four-entry queue and enter a four-stage decode pipeline
// one per cycle while output credits remain, passing the filter register and
// the middle queue first. The pipeline issues only against free output queue
// slots (eight), so a stalled consumer backs up into the middle queue and then
// into full; throughput is one transaction per cycle while pop keeps up.
// ----------------------------------------------------------------------------
module anchor_box_landmark_decoder #(
    parameter int MAX_ANCHORS = 4,
    parameter int GRID_SIZE   = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // items in
    input  logic               push,
    output logic               full,
    input  logic               i_kind,
    input  logic [7:0]         i_row,
    input  logic [7:0]         i_col,
    input  logic [1:0]         i_anchor_index,
    input  logic [15:0]        i_score,
    input  logic signed [15:0] i_delta_a,
    input  logic signed [15:0] i_delta_b,
    input  logic signed [15:0] i_delta_c,
    input  logic signed [15:0] i_delta_d,
    // results out
    output logic               empty,
    input  logic               pop,
    output logic               o_kind_out,
    output logic [7:0]         o_row_out,
    output logic [7:0]         o_col_out,
    output logic [1:0]         o_anchor_out,
    output logic [15:0]        o_score_out,
    output logic signed [15:0] o_out_x1,
    output logic signed [15:0] o_out_y1,
    output logic signed [15:0] o_out_x2,
    output logic signed [15:0] o_out_y2,
    output logic               o_clipped
);
    import abld_pkg::*;

    localparam int MCW = $clog2(MID_DEPTH+1);
    localparam int OCW = $clog2(OUT_DEPTH+1);

    // configuration registers
    logic [6:0]  r_stride;
    logic [15:0] r_threshold;
    logic [2:0]  r_in_use;
    t_anchor_set r_anchor;
    logic        cfg_we;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride    <= '0;
            r_threshold <= 16'd52429;
            r_in_use    <= 3'd2;
            r_anchor    <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_STRIDE:    r_stride    <= pwdata[6:0];
                REG_THRESHOLD: r_threshold <= pwdata[15:0];
                REG_IN_USE:    r_in_use    <= pwdata[2:0];
                REG_ANCHOR_0:  r_anchor[0] <= pwdata;
                REG_ANCHOR_1:  r_anchor[1] <= pwdata;
                REG_ANCHOR_2:  r_anchor[2] <= pwdata;
                REG_ANCHOR_3:  r_anchor[3] <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STRIDE:    prdata = 64'(r_stride);
            REG_THRESHOLD: prdata = 64'(r_threshold);
            REG_IN_USE:    prdata = 64'(r_in_use);
            REG_ANCHOR_0:  prdata = r_anchor[0];
            REG_ANCHOR_1:  prdata = r_anchor[1];
            REG_ANCHOR_2:  prdata = r_anchor[2];
            REG_ANCHOR_3:  prdata = r_anchor[3];
            default:       prdata = '0;
        endcase
    end

    // front: accept and filter
    t_item    in_item;
    logic     in_accept;
    logic     front_v;
    t_item    front_item;
    logic [MCW-1:0] mid_count;
    logic     mid_empty;
    t_item    mid_item;

    assign in_item = '{i_kind, i_row, i_col, i_anchor_index, i_score,
                       i_delta_a, i_delta_b, i_delta_c, i_delta_d};
    // Reserve a slot for the item sitting in the filter register.
    assign full      = (32'(mid_count) + 32'(front_v)) >= MID_DEPTH;
    assign in_accept = push && !full;

    abld_front #(
        .MAX_ANCHORS (MAX_ANCHORS),
        .GRID_SIZE   (GRID_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (in_item),
        .i_threshold (r_threshold),
        .i_in_use    (r_in_use),
        .o_valid     (front_v),
        .o_item      (front_item)
    );

    // middle queue decouples filter from decode
    logic mid_pop;

    abld_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_v),
        .i_data  (front_item),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    // Issue only against a free output slot; credits return on pop.
    logic [OCW-1:0] r_credit, n_credit;
    logic           out_pop;

    assign mid_pop = !mid_empty && (r_credit != '0);

    always_comb begin
        n_credit = r_credit - OCW'(mid_pop) + OCW'(out_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= OCW'(OUT_DEPTH);
        end else begin
            r_credit <= n_credit;
        end
    end

    // back: decode pipeline
    logic    back_v;
    t_result back_res;

    abld_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mid_pop),
        .i_item   (mid_item),
        .i_stride (r_stride),
        .i_anchor (r_anchor),
        .o_valid  (back_v),
        .o_result (back_res)
    );

    // output queue
    t_result        out_res;
    logic [OCW-1:0] out_count;

    assign out_pop = pop && !empty;

    abld_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_v),
        .i_data  (back_res),
        .i_pop   (out_pop),
        .o_data  (out_res),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_kind_out   = out_res.meta.kind;
    assign o_row_out    = out_res.meta.row;
    assign o_col_out    = out_res.meta.col;
    assign o_anchor_out = out_res.meta.ai;
    assign o_score_out  = out_res.meta.score;
    assign o_out_x1     = out_res.x1;
    assign o_out_y1     = out_res.y1;
    assign o_out_x2     = out_res.x2;
    // count gates o_clipped low while the queue is empty; empty also gates pop
    assign o_out_y2     = out_res.y2;
    assign o_clipped    = out_res.clip & (out_count != '0);
endmodule
